>>> sv/sitrd_pkg.sv
// Shared types and constants for the signed integer to radix digits block.
package sitrd_pkg;

	localparam int CFG_W       = 64;
	localparam int CFG_INDEX_W = 1;
	localparam int SYM_W       = 8;
	localparam int SLOTS       = 16;
	localparam int RADIX_W     = 5;
	localparam int DIGIT_W     = 4;
	localparam int DIV_BITS    = 8;
	localparam int MIN_RADIX   = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_SYMBOLS_LOW  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_SYMBOLS_HIGH = 1'b1;

	localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [SYM_W-1:0] CH_NUL   = 8'h00;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_SIGN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic push_sign;
		logic push_digit;
	} cmd_t;

	typedef struct packed {
		logic alpha_ok;
		logic div_done;
		logic neg;
		logic last_digit;
		logic out_free;
	} status_t;

endpackage

>>> sv/sitrd_ctrl.sv
// Controller state machine: load, divide, sign and digit emission sequencing.
module sitrd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  sitrd_pkg::status_t status,
	output sitrd_pkg::cmd_t    cmd
);
	import sitrd_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && status.alpha_ok) state_d = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (status.div_done) state_d = ST_SIGN;
			end
			ST_SIGN: begin
				if (!status.neg || status.out_free) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free && status.last_digit) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid && status.alpha_ok;
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
			end
			ST_SIGN: begin
				cmd.push_sign = status.neg && status.out_free;
			end
			ST_EMIT: begin
				cmd.push_digit = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

>>> sv/sitrd_dp.sv
// Datapath: alphabet registers and check, chunked divider, digit store, output word.
module sitrd_dp #(
	parameter int MAX_SYMBOLS = 16,
	parameter int NUMBER_BITS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [sitrd_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [sitrd_pkg::CFG_W-1:0]        cfg_data,
	input  logic signed [NUMBER_BITS-1:0]      number,
	input  sitrd_pkg::cmd_t                    cmd,
	output sitrd_pkg::status_t                 status,
	input  logic                               out_ready,
	output logic                               out_valid,
	output logic [sitrd_pkg::SYM_W-1:0]        out_char,
	output logic                               is_last
);
	import sitrd_pkg::*;

	localparam int DIV_CYCLES = (NUMBER_BITS + DIV_BITS - 1) / DIV_BITS;
	localparam int MAG_W      = DIV_CYCLES * DIV_BITS;
	localparam int CHUNK_W    = $clog2(DIV_CYCLES + 1);
	localparam int IDX_W      = $clog2(NUMBER_BITS);
	localparam int CNT_W      = $clog2(NUMBER_BITS + 1);

	logic [CFG_W-1:0]   sym_lo_q;
	logic [CFG_W-1:0]   sym_hi_q;
	logic [SYM_W-1:0]   syms [SLOTS];
	logic [RADIX_W-1:0] alpha_len;
	logic               alpha_ok;

	logic [MAG_W-1:0]   mag_q;
	logic [DIGIT_W-1:0] rem_q;
	logic [RADIX_W-1:0] radix_q;
	logic               neg_q;
	logic [CHUNK_W-1:0] chunk_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [DIGIT_W-1:0] digit_q [NUMBER_BITS];

	logic [NUMBER_BITS-1:0] mag_in;
	logic [MAG_W-1:0]       m_next;
	logic [DIGIT_W-1:0]     r_next;
	logic                   div_last;
	logic [CNT_W-1:0]       ptr;

	logic                   out_valid_q;
	logic [SYM_W-1:0]       out_char_q;
	logic                   is_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_lo_q <= '0;
			sym_hi_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SYMBOLS_LOW:  sym_lo_q <= cfg_data;
				REG_SYMBOLS_HIGH: sym_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < SLOTS / 2; i++) begin
			syms[i]             = sym_lo_q[i*SYM_W +: SYM_W];
			syms[i + SLOTS / 2] = sym_hi_q[i*SYM_W +: SYM_W];
		end
	end

	always_comb begin
		alpha_len = RADIX_W'(MAX_SYMBOLS);
		for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
			if (syms[i] == CH_NUL) alpha_len = RADIX_W'(i);
		end
	end

	always_comb begin
		alpha_ok = (alpha_len >= RADIX_W'(MIN_RADIX));
		for (int i = 0; i < MAX_SYMBOLS; i++) begin
			if (RADIX_W'(i) < alpha_len) begin
				if (syms[i] == CH_PLUS || syms[i] == CH_MINUS) alpha_ok = 1'b0;
				for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
					if (RADIX_W'(j) < alpha_len && syms[i] == syms[j]) alpha_ok = 1'b0;
				end
			end
		end
	end

	assign mag_in = number[NUMBER_BITS-1] ? NUMBER_BITS'(~number + 1'b1) : number;

	always_comb begin
		logic [RADIX_W-1:0] t;
		logic               qb;
		r_next = rem_q;
		m_next = mag_q;
		for (int k = 0; k < DIV_BITS; k++) begin
			t = {r_next, m_next[MAG_W-1]};
			if (t >= radix_q) begin
				t  = t - radix_q;
				qb = 1'b1;
			end else begin
				qb = 1'b0;
			end
			r_next = t[DIGIT_W-1:0];
			m_next = {m_next[MAG_W-2:0], qb};
		end
	end

	assign div_last = (chunk_q == CHUNK_W'(DIV_CYCLES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_q <= '0;
			cnt_q   <= '0;
		end else if (cmd.load) begin
			chunk_q <= '0;
			cnt_q   <= '0;
		end else if (cmd.div_step) begin
			if (div_last) begin
				chunk_q <= '0;
				cnt_q   <= cnt_q + CNT_W'(1);
			end else begin
				chunk_q <= chunk_q + CHUNK_W'(1);
			end
		end else if (cmd.push_digit) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q   <= MAG_W'(mag_in);
			rem_q   <= '0;
			radix_q <= alpha_len;
			neg_q   <= number[NUMBER_BITS-1];
		end else if (cmd.div_step) begin
			mag_q <= m_next;
			rem_q <= div_last ? '0 : r_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_step && div_last) digit_q[cnt_q[IDX_W-1:0]] <= r_next;
	end

	assign ptr = cnt_q - CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push_sign || cmd.push_digit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_sign) begin
			out_char_q <= CH_MINUS;
			is_last_q  <= 1'b0;
		end else if (cmd.push_digit) begin
			out_char_q <= syms[digit_q[ptr[IDX_W-1:0]]];
			is_last_q  <= status.last_digit;
		end
	end

	always_comb begin
		status.alpha_ok   = alpha_ok;
		status.div_done   = div_last && (m_next == '0);
		status.neg        = neg_q;
		status.last_digit = (cnt_q == CNT_W'(1));
		status.out_free   = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign is_last   = is_last_q;

endmodule

>>> sv/signed_integer_to_radix_digits.sv
// Top level: signed integer to text in a radix set by a configured symbol alphabet.
// The divider retires 8 quotient bits a cycle; a minus sign for a negative number comes first,
// then the digits. A new number is accepted only in idle, once the last character of the
// previous number is in the output register; characters leave one per cycle while out_ready is high.
// An invalid alphabet drops the number in its accept cycle with no output.
// Reset (arst_n low, async) clears both alphabet registers, so numbers drop until configured.
module signed_integer_to_radix_digits #(
	parameter int MAX_SYMBOLS = 16,
	parameter int NUMBER_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [sitrd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [sitrd_pkg::CFG_W-1:0]       cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [NUMBER_BITS-1:0]     number,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [sitrd_pkg::SYM_W-1:0]       out_char,
	output logic                              is_last
);
	import sitrd_pkg::*;

	cmd_t    cmd;
	status_t status;

	sitrd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	sitrd_dp #(
		.MAX_SYMBOLS (MAX_SYMBOLS),
		.NUMBER_BITS (NUMBER_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.number    (number),
		.cmd       (cmd),
		.status    (status),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_char  (out_char),
		.is_last   (is_last)
	);

endmodule

>>> sv/sitrd_checker.sv
// Port-level checker for the radix digits block, bound to the top level.
module sitrd_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [sitrd_pkg::SYM_W-1:0] out_char,
	input logic                       is_last
);
	import sitrd_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(is_last))
		else $error("output word changed while stalled");

	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid && in_ready)
		else $error("block not idle in reset");

	a_no_bad_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_char != CH_PLUS && out_char != CH_NUL)
		else $error("plus or zero byte emitted");

	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_char == CH_MINUS |-> !is_last)
		else $error("sign marked as last character");

endmodule

bind signed_integer_to_radix_digits sitrd_checker u_sitrd_checker (.*);
